@@ hw/rtl/aou_pkg.sv @@
// Adam update unit: shared constants, register codes and pipeline stage types.
// Used by aou_div, aou_isqrt, adam_optimizer_update_unit, adam_update_checker and tb; no dependencies.
package aou_pkg;

  localparam int NUM_PARAMS = 4096;
  localparam int IDX_W      = $clog2(NUM_PARAMS);
  localparam int DIV_STEPS  = 64;
  localparam int ISQ_STEPS  = 32;

  // configuration register indexes
  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_LEARNING_RATE = 2'd0;
  localparam reg_index_t REG_BETA_FIRST    = 2'd1;
  localparam reg_index_t REG_BETA_SECOND   = 2'd2;
  localparam reg_index_t REG_EPSILON_TERM  = 2'd3;

  localparam logic [23:0] LR_RESET    = 24'd16777;
  localparam logic [15:0] BETA1_RESET = 16'd58982;
  localparam logic [15:0] BETA2_RESET = 16'd65470;
  localparam logic [31:0] EPS_RESET   = 32'd43;

  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [63:0] VMAX     = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] STEP_CAP = 64'h0000_0002_0000_0000;

  // one restoring divider stage
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] quo;
    logic [63:0] dvs;
    logic        ovf;
  } div_stage_t;

  // one square root stage
  typedef struct packed {
    logic [63:0] x;
    logic [63:0] res;
  } isq_stage_t;

  // item context carried alongside the long arithmetic units
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [31:0]      cur;
    logic             msign;
    logic             sat;
    logic [63:0]      mhat;
    logic [4:0]       shr;
  } side_t;

endpackage

@@ hw/rtl/aou_div.sv @@
// Pipelined restoring divider: floor({num_hi,num_lo} / divisor), one quotient bit a stage.
// Depends on aou_pkg. Gives all ones when the quotient overflows 64 bits or divisor is zero.
module aou_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num_hi,
  input  logic [63:0] num_lo,
  input  logic [63:0] divisor,
  output logic [63:0] quotient
);
  import aou_pkg::*;

  div_stage_t st [DIV_STEPS];
  div_stage_t st_next [DIV_STEPS];

  // work out every stage from the one before it
  always_comb begin
    div_stage_t prev;
    logic [64:0] t;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        prev.rem = num_hi;
        prev.lo  = num_lo;
        prev.quo = '0;
        prev.dvs = divisor;
        prev.ovf = (divisor == 64'd0) || (num_hi >= divisor);
      end else begin
        prev = st[k-1];
      end
      t = {prev.rem, prev.lo[63]};
      st_next[k].quo = {prev.quo[62:0], 1'b0};
      if (t >= {1'b0, prev.dvs}) begin
        t = t - {1'b0, prev.dvs};
        st_next[k].quo[0] = 1'b1;
      end
      st_next[k].rem = t[63:0];
      st_next[k].lo  = {prev.lo[62:0], 1'b0};
      st_next[k].dvs = prev.dvs;
      st_next[k].ovf = prev.ovf;
    end
  end

  // advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

  assign quotient = st[DIV_STEPS-1].ovf ? {64{1'b1}} : st[DIV_STEPS-1].quo;

endmodule

@@ hw/rtl/aou_isqrt.sv @@
// Pipelined integer square root of a 64-bit value, two radicand bits a stage.
// Depends on aou_pkg.
module aou_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [63:0] root
);
  import aou_pkg::*;

  isq_stage_t st [ISQ_STEPS];
  isq_stage_t st_next [ISQ_STEPS];

  // one digit-by-digit step per stage, trial bit fixed by position
  always_comb begin
    isq_stage_t prev;
    logic [63:0] bitv;
    logic [63:0] trial;
    for (int k = 0; k < ISQ_STEPS; k++) begin
      if (k == 0) begin
        prev.x   = radicand;
        prev.res = '0;
      end else begin
        prev = st[k-1];
      end
      bitv  = 64'd1 << (62 - 2 * k);
      trial = prev.res + bitv;
      if (prev.x >= trial) begin
        st_next[k].x   = prev.x - trial;
        st_next[k].res = (prev.res >> 1) + bitv;
      end else begin
        st_next[k].x   = prev.x;
        st_next[k].res = prev.res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

  assign root = st[ISQ_STEPS-1].res;

endmodule

@@ hw/rtl/adam_optimizer_update_unit.sv @@
// Adam update unit top level: moment memories, beta powers and the update pipeline.
// Depends on aou_pkg, aou_div and aou_isqrt.
//
// One parameter enters per cycle while item_stall is low, and its updated value leaves after
// four front stages, a 64-stage divider for the bias corrections, two normalising stages,
// a 32-stage square root, three step product stages, a second 64-stage divider and the
// output register. The whole pipeline advances together and holds while a result is
// stalled. After reset the moment memories are cleared one entry a cycle, during which
// item_stall is high; configuration writes are taken at any time.
// Back-to-back items on the same index are handled by forwarding the moments just written.
module adam_optimizer_update_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [11:0]           param_index,
  input  logic signed [31:0]    gradient,
  input  logic signed [31:0]    current_value,
  input  logic                  new_step,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [11:0]           result_index,
  output logic signed [31:0]    updated_value,
  output logic                  saturated,
  input  logic                  cfg_write,
  input  aou_pkg::reg_index_t   cfg_index,
  input  logic [31:0]           cfg_data
);
  import aou_pkg::*;

  logic [23:0] learning_rate;
  logic [15:0] beta_first;
  logic [15:0] beta_second;
  logic [31:0] epsilon_term;
  logic [32:0] bp1, bp2;
  logic        step_started;
  logic        clr_busy;
  logic [IDX_W-1:0] clr_addr;
  logic        en, acc;

  assign en         = !result_valid || !result_stall;
  assign item_stall = clr_busy || !en;
  assign acc        = item_valid && !item_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      beta_first    <= BETA1_RESET;
      beta_second   <= BETA2_RESET;
      epsilon_term  <= EPS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEARNING_RATE: learning_rate <= cfg_data[23:0];
        REG_BETA_FIRST:    beta_first    <= cfg_data[15:0];
        REG_BETA_SECOND:   beta_second   <= cfg_data[15:0];
        REG_EPSILON_TERM:  epsilon_term  <= cfg_data;
        default: ;
      endcase
    end
  end

  // running beta powers, advanced when an accepted transaction opens a step or is the first after reset
  logic [32:0] bp1_next, bp2_next;
  always_comb begin
    bp1_next = bp1;
    bp2_next = bp2;
    if (new_step || !step_started) begin
      bp1_next = 33'((49'(bp1) * 49'(beta_first)) >> 16);
      bp2_next = 33'((49'(bp2) * 49'(beta_second)) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bp1          <= ONE_Q32;
      bp2          <= ONE_Q32;
      step_started <= 1'b0;
    end else if (acc) begin
      bp1          <= bp1_next;
      bp2          <= bp2_next;
      step_started <= 1'b1;
    end
  end

  // front stages
  logic             v1, v2, v3, v4;
  logic [IDX_W-1:0] idx1, idx2, idx3, idx4;
  logic [31:0]      cur1, cur2, cur3, cur4;
  logic signed [31:0] g1, g2;
  logic [32:0]      p1a, p1b, p2a, p2b, p3a, p3b, p4a, p4b;
  logic [47:0]      gsq2;
  logic             sat2, sat3, sat4;
  logic signed [49:0] tg3;
  logic [64:0]      tv3;
  logic signed [31:0] rdm, m4;
  logic [47:0]      rdv, vm4;

  logic [31:0] gmag;
  logic [63:0] gsq_full;
  assign gmag     = g1[31] ? 32'(-g1) : 32'(g1);
  assign gsq_full = 64'(gmag) * 64'(gmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // take the transaction, square the gradient, form the new-sample terms
  always_ff @(posedge clk) begin
    if (en) begin
      idx1 <= param_index;
      g1   <= gradient;
      cur1 <= current_value;
      p1a  <= bp1_next;
      p1b  <= bp2_next;

      idx2 <= idx1;
      g2   <= g1;
      cur2 <= cur1;
      p2a  <= p1a;
      p2b  <= p1b;
      sat2 <= gsq_full > VMAX;
      gsq2 <= (gsq_full > VMAX) ? VMAX[47:0] : gsq_full[47:0];

      idx3 <= idx2;
      cur3 <= cur2;
      p3a  <= p2a;
      p3b  <= p2b;
      sat3 <= sat2;
      tg3  <= 50'($signed({1'b0, 17'h10000 - {1'b0, beta_first}}) * g2);
      tv3  <= 65'(17'h10000 - {1'b0, beta_second}) * 65'(gsq2);
    end
  end

  // moment update with forwarding of the entry just written by the item ahead
  logic signed [31:0] mo, m_new;
  logic [47:0]        vo, v_new;
  logic signed [50:0] m_sum;
  logic [65:0]        v_sum;
  always_comb begin
    mo = rdm;
    vo = rdv;
    if (v4 && idx4 == idx3) begin
      mo = m4;
      vo = vm4;
    end
    m_sum = 51'($signed({1'b0, beta_first}) * mo) + 51'(tg3);
    m_new = m_sum[47:16];
    v_sum = 66'(66'(beta_second) * 66'(vo)) + 66'(tv3);
    v_new = v_sum[63:16];
  end

  logic [31:0] m_mem [NUM_PARAMS];
  logic [47:0] v_mem [NUM_PARAMS];

  // clear after reset, then read ahead and write back
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      m_mem[clr_addr] <= '0;
      v_mem[clr_addr] <= '0;
    end else if (en && v3) begin
      m_mem[idx3] <= m_new;
      v_mem[idx3] <= v_new;
    end
    if (en) begin
      rdm <= m_mem[idx2];
      rdv <= v_mem[idx2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(NUM_PARAMS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx4 <= idx3;
      cur4 <= cur3;
      p4a  <= p3a;
      p4b  <= p3b;
      sat4 <= sat3;
      m4   <= m_new;
      vm4  <= v_new;
    end
  end

  // bias corrections
  logic [31:0] mmag;
  logic [63:0] mhat_q, vhat_q;
  assign mmag = m4[31] ? 32'(-m4) : 32'(m4);

  aou_div u_div_m (
    .clk      (clk),
    .en       (en),
    .num_hi   (64'd0),
    .num_lo   ({mmag, 32'h0}),
    .divisor  (64'(ONE_Q32 - p4a)),
    .quotient (mhat_q)
  );

  aou_div u_div_v (
    .clk      (clk),
    .en       (en),
    .num_hi   (64'(vm4[47:32])),
    .num_lo   ({vm4[31:0], 32'h0}),
    .divisor  (64'(ONE_Q32 - p4b)),
    .quotient (vhat_q)
  );

  side_t s4;
  always_comb begin
    s4       = '0;
    s4.valid = v4;
    s4.idx   = idx4;
    s4.cur   = cur4;
    s4.msign = m4[31];
    s4.sat   = sat4;
  end

  side_t da [DIV_STEPS];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) da[k].valid <= 1'b0;
    end else if (en) begin
      da[0] <= s4;
      for (int k = 1; k < DIV_STEPS; k++) da[k] <= da[k-1];
    end
  end

  // pick the normalising shift, then shift
  logic [5:0]  shift_s;
  always_comb begin
    shift_s = '0;
    for (int k = 1; k <= 16; k++) begin
      if ((vhat_q >> (64 - 2 * k)) == 64'd0) shift_s = 6'(2 * k);
    end
  end

  side_t q1, q2;
  side_t q1_next, q2_next;
  logic [63:0] vhat1, xs2;
  logic [5:0]  s1;

  // attach the corrected first moment, then the root's shift back
  always_comb begin
    q1_next      = da[DIV_STEPS-1];
    q1_next.mhat = mhat_q;
    q2_next      = q1;
    q2_next.shr  = 5'((6'd32 - s1) >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1.valid <= 1'b0;
      q2.valid <= 1'b0;
    end else if (en) begin
      q1 <= q1_next;
      q2 <= q2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vhat1 <= vhat_q;
      s1    <= shift_s;
      xs2   <= vhat1 << s1;
    end
  end

  logic [63:0] res_q;
  aou_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (xs2),
    .root     (res_q)
  );

  side_t sq [ISQ_STEPS];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ISQ_STEPS; k++) sq[k].valid <= 1'b0;
    end else if (en) begin
      sq[0] <= q2;
      for (int k = 1; k < ISQ_STEPS; k++) sq[k] <= sq[k-1];
    end
  end

  // denominator, step product in two partial products, then summed
  logic [63:0] den_sum;
  assign den_sum = (res_q << sq[ISQ_STEPS-1].shr) + 64'(epsilon_term);

  side_t r1, r2, r3;
  logic [63:0] den1, den2, den3;
  logic [63:0] pl2, ph2;
  logic [63:0] nhi3, nlo3;
  logic [95:0] prod;
  logic [31:0] lr_q;
  assign lr_q = {learning_rate, 8'h0};
  assign prod = 96'(pl2) + {ph2, 32'h0};

  always_ff @(posedge clk) begin
    if (rst) begin
      r1.valid <= 1'b0;
      r2.valid <= 1'b0;
      r3.valid <= 1'b0;
    end else if (en) begin
      r1 <= sq[ISQ_STEPS-1];
      r2 <= r1;
      r3 <= r2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den1 <= (den_sum == 64'd0) ? 64'd1 : den_sum;
      den2 <= den1;
      pl2  <= 64'(r1.mhat[31:0]) * 64'(lr_q);
      ph2  <= 64'(r1.mhat[63:32]) * 64'(lr_q);
      den3 <= den2;
      nhi3 <= 64'(prod[95:64]);
      nlo3 <= prod[63:0];
    end
  end

  logic [63:0] step_q;
  aou_div u_div_step (
    .clk      (clk),
    .en       (en),
    .num_hi   (nhi3),
    .num_lo   (nlo3),
    .divisor  (den3),
    .quotient (step_q)
  );

  side_t dc [DIV_STEPS];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) dc[k].valid <= 1'b0;
    end else if (en) begin
      dc[0] <= r3;
      for (int k = 1; k < DIV_STEPS; k++) dc[k] <= dc[k-1];
    end
  end

  // cap the step, apply it and clip to the value range
  side_t fin;
  logic [33:0]        step_c;
  logic signed [35:0] nv;
  logic signed [31:0] nv_c;
  logic               nv_sat;
  assign fin = dc[DIV_STEPS-1];
  always_comb begin
    step_c = (step_q > STEP_CAP) ? STEP_CAP[33:0] : step_q[33:0];
    if (fin.msign) begin
      nv = 36'($signed(fin.cur)) + $signed({2'b0, step_c});
    end else begin
      nv = 36'($signed(fin.cur)) - $signed({2'b0, step_c});
    end
    nv_sat = 1'b0;
    nv_c   = nv[31:0];
    if (nv > 36'sh0_7FFF_FFFF) begin
      nv_c   = 32'sh7FFF_FFFF;
      nv_sat = 1'b1;
    end else if (nv < -36'sh0_8000_0000) begin
      nv_c   = -32'sh8000_0000;
      nv_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_index  <= fin.idx;
      updated_value <= nv_c;
      saturated     <= fin.sat || nv_sat;
    end
  end

endmodule

@@ verif/adam_update_checker.sv @@
// Adam update checker: watches the item, result and register channels, predicts each
// updated value and compares it with the block's output. Depends on aou_pkg.
module adam_update_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_stall,
  input  logic [11:0]         param_index,
  input  logic signed [31:0]  gradient,
  input  logic signed [31:0]  current_value,
  input  logic                new_step,
  input  logic                result_valid,
  input  logic                result_stall,
  input  logic [11:0]         result_index,
  input  logic signed [31:0]  updated_value,
  input  logic                saturated,
  input  logic                cfg_write,
  input  aou_pkg::reg_index_t cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  pending
);
  import aou_pkg::*;

  typedef struct {
    logic [11:0] idx;
    logic [31:0] val;
    logic        sat;
  } update_t;

  update_t     expected_updates[$];
  logic [23:0] lr;
  logic [15:0] b1, b2;
  logic [31:0] eps;
  int          mom1[NUM_PARAMS];
  logic [47:0] mom2[NUM_PARAMS];
  logic [63:0] pow1, pow2;
  logic        started;

  // floor(a*b/c) over 128 bits; all ones on overflow or a zero divisor
  function automatic logic [63:0] scale_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (c == 0 || p[127:64] >= c) return '1;
    return 64'(p / {64'd0, c});
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, bt;
    r  = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  // advance the moments of one parameter and work out its new value
  function automatic update_t predict_update(logic [11:0] idx, logic signed [31:0] g32,
                                             logic signed [31:0] cur32, logic ns);
    update_t     u;
    int          slot;
    longint      g, m, nv;
    logic [63:0] gmag, gsq, v, mmag, mhat, vhat, root, den, stp;
    int          s;
    slot = idx % NUM_PARAMS;
    g    = g32;
    u.sat = 1'b0;
    if (ns || !started) begin
      pow1 = (pow1 * 64'(b1)) >> 16;
      pow2 = (pow2 * 64'(b2)) >> 16;
      started = 1'b1;
    end
    m = (longint'(b1) * longint'(mom1[slot]) + (longint'(65536) - longint'(b1)) * g) >>> 16;
    mom1[slot] = int'(m);
    gmag = (g < 0) ? 64'(-g) : 64'(g);
    gsq  = gmag * gmag;
    if (gsq > VMAX) begin
      gsq   = VMAX;
      u.sat = 1'b1;
    end
    v = (64'(b2) * 64'(mom2[slot]) + (64'd65536 - 64'(b2)) * gsq) >> 16;
    mom2[slot] = v[47:0];
    mmag = (m < 0) ? 64'(-m) : 64'(m);
    mhat = scale_div(mmag, 64'(ONE_Q32), 64'(ONE_Q32) - pow1);
    vhat = scale_div(v, 64'(ONE_Q32), 64'(ONE_Q32) - pow2);
    s = 32;
    while (s > 0 && (vhat >> (64 - s)) != 0) s -= 2;
    root = int_sqrt(vhat << s) << ((32 - s) / 2);
    den  = root + 64'(eps);
    if (den == 0) den = 1;
    stp = scale_div(mhat, 64'(lr) << 8, den);
    if (stp > STEP_CAP) stp = STEP_CAP;
    nv = (m < 0) ? longint'(cur32) + longint'(stp) : longint'(cur32) - longint'(stp);
    if (nv > 64'sd2147483647) begin
      nv    = 64'sd2147483647;
      u.sat = 1'b1;
    end else if (nv < -64'sd2147483648) begin
      nv    = -64'sd2147483648;
      u.sat = 1'b1;
    end
    u.idx = idx;
    u.val = nv[31:0];
    return u;
  endfunction

  // track registers, predict each accepted item, compare each accepted result
  always @(posedge clk) begin
    update_t exp_u;
    if (rst) begin
      lr      <= LR_RESET;
      b1      <= BETA1_RESET;
      b2      <= BETA2_RESET;
      eps     <= EPS_RESET;
      pow1    = 64'(ONE_Q32);
      pow2    = 64'(ONE_Q32);
      started = 1'b0;
      for (int i = 0; i < NUM_PARAMS; i++) begin
        mom1[i] = 0;
        mom2[i] = 0;
      end
      expected_updates.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_LEARNING_RATE: lr  <= cfg_data[23:0];
          REG_BETA_FIRST:    b1  <= cfg_data[15:0];
          REG_BETA_SECOND:   b2  <= cfg_data[15:0];
          REG_EPSILON_TERM:  eps <= cfg_data;
          default: ;
        endcase
      end
      // queue the prediction behind those still outstanding
      if (item_valid && !item_stall)
        expected_updates.insert(expected_updates.size(),
                                predict_update(param_index, gradient, current_value,
                                               new_step));
      if (result_valid && !result_stall) begin
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected transaction idx=%0d value=%0d sat=%0b", $time,
                   result_index, updated_value, saturated);
          errors <= errors + 1;
        end else begin
          exp_u = expected_updates.pop_front();
          if (result_index !== exp_u.idx || updated_value !== exp_u.val ||
              saturated !== exp_u.sat) begin
            $display({"%0t: mismatch expected idx=%0d value=%0d sat=%0b, ",
                      "got idx=%0d value=%0d sat=%0b"},
                     $time, exp_u.idx, $signed(exp_u.val), exp_u.sat, result_index,
                     updated_value, saturated);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_updates.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the Adam update unit: clock, reset, stimulus, result back-pressure
// and verdict. Depends on aou_pkg, adam_optimizer_update_unit and adam_update_checker.
module tb;
  import aou_pkg::*;

  localparam int IDLE_LIMIT = 25000;

  logic               clk, rst;
  logic               item_valid, item_stall;
  logic [11:0]        param_index;
  logic signed [31:0] gradient, current_value;
  logic               new_step;
  logic               result_valid, result_stall;
  logic [11:0]        result_index;
  logic signed [31:0] updated_value;
  logic               saturated;
  logic               cfg_write;
  reg_index_t         cfg_index;
  logic [31:0]        cfg_data;
  int                 errors, pending, idle_cycles;
  bit                 tx_burst, rx_burst, long_hold;

  adam_optimizer_update_unit u_top (.*);

  adam_update_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int  n;
    bit  ok;
    result_stall <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        result_stall <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      n = rx_burst ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do begin
        @(negedge clk);
        ok = result_valid;
        @(posedge clk);
      end while (!ok);
    end
  end

  // offer one item after a random gap and hold it until taken
  task automatic send_item(logic [11:0] idx, logic [31:0] g, logic [31:0] cur, logic ns);
    int gap;
    bit ok;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid    <= 1'b1;
    param_index   <= idx;
    gradient      <= g;
    current_value <= cur;
    new_step      <= ns;
    do begin
      @(negedge clk);
      ok = !item_stall;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // hold off the sender until every update is back and the pipeline is empty
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_random(int count, bit pressure);
    logic [11:0] idx;
    logic [31:0] g, cur;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
      if (pressure && i == 40) begin
        long_hold = 1'b1;
        tx_burst  = 1'b1;
      end
      if (pressure && i == 300) tx_burst = 1'b0;
      idx = ($urandom_range(0, 99) < 80) ? 12'($urandom_range(0, 15))
                                         : 12'($urandom_range(0, 4095));
      g   = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 2097151)) - 32'd1048576
                                        : $urandom;
      cur = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 4194303)) - 32'd2097152
                                        : $urandom;
      send_item(idx, g, cur, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    rst           <= 1'b1;
    item_valid    <= 1'b0;
    param_index   <= '0;
    gradient      <= '0;
    current_value <= '0;
    new_step      <= 1'b0;
    cfg_write     <= 1'b0;
    cfg_index     <= REG_LEARNING_RATE;
    cfg_data      <= '0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    long_hold     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: field extremes, clipped square, clipped result, repeated index
    send_item(12'd0, 32'd0, 32'd0, 1'b1);
    send_item(12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_item(12'd4095, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(12'd1, 32'h8000_0000, 32'd0, 1'b0);
    send_item(12'd1, 32'h8000_0000, 32'd0, 1'b1);
    send_item(12'd2, 32'd1, 32'd65536, 1'b0);
    send_item(12'd2, 32'hFFFF_FFFF, 32'hFFFF_0000, 1'b0);
    send_item(12'd3, 32'hFFF0_0000, 32'h7FFF_FFF0, 1'b0);
    send_item(12'd4, 32'h0010_0000, 32'h8000_0010, 1'b1);
    send_random(200, 1'b1);
    drain();

    // lowest decays and epsilon, largest rate: zero divisor and capped step
    write_reg(REG_LEARNING_RATE, 32'h00FF_FFFF);
    write_reg(REG_BETA_FIRST, 32'd0);
    write_reg(REG_BETA_SECOND, 32'd0);
    write_reg(REG_EPSILON_TERM, 32'd0);
    send_item(12'd100, 32'd0, 32'd5, 1'b1);
    send_item(12'd101, 32'h7FFF_FFFF, 32'd0, 1'b1);
    send_item(12'd102, 32'hFFFF_FFFB, 32'h7FFF_FFFF, 1'b0);
    send_item(12'd103, 32'd1, 32'h8000_0000, 1'b0);
    send_random(130, 1'b0);
    drain();

    // highest decays and epsilon, zero rate
    write_reg(REG_LEARNING_RATE, 32'd0);
    write_reg(REG_BETA_FIRST, 32'h0000_FFFF);
    write_reg(REG_BETA_SECOND, 32'h0000_FFFF);
    write_reg(REG_EPSILON_TERM, 32'hFFFF_FFFF);
    send_random(130, 1'b0);
    drain();

    // random settings
    write_reg(REG_LEARNING_RATE, $urandom);
    write_reg(REG_BETA_FIRST, $urandom);
    write_reg(REG_BETA_SECOND, 32'($urandom_range(60000, 65535)));
    write_reg(REG_EPSILON_TERM, 32'($urandom_range(0, 65535)));
    send_random(130, 1'b0);
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/aou_pkg.sv
hw/rtl/aou_div.sv
hw/rtl/aou_isqrt.sv
hw/rtl/adam_optimizer_update_unit.sv
verif/adam_update_checker.sv
verif/tb.sv
